### design/legged_gait_phase_generator_core_macros.svh
// ============================================================================
// legged gait phase generator assertion macros
// shared concurrent assertion forms, clocked and gated by the active-low reset
// ============================================================================
`ifndef LEGGED_GAIT_PHASE_GENERATOR_CORE_MACROS_SVH
`define LEGGED_GAIT_PHASE_GENERATOR_CORE_MACROS_SVH

// same-cycle implication
`define LGPG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LGPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lgpg_pkg.sv
// ============================================================================
// lgpg_pkg
// shared types, constants and the quarter-wave sine table builder
// ============================================================================
package lgpg_pkg;

    // leg slots carried on the ports and legs actually computed
    localparam int SLOTS     = 4;
    localparam int LEG_COUNT = 4;
    localparam int LEG_W     = 2;

    // quarter-wave sine table
    localparam int SINE_DEPTH  = 256;
    localparam int SINE_ADDR_W = $clog2(SINE_DEPTH);
    localparam int SINE_MAG_W  = 15;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // field widths
    localparam int FIELD_W = 16;
    localparam int IN_W    = 80;
    localparam int OUT_W   = 192;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // swing cubic widths: u is Q0.16 up to one, g is Q0.48 up to one
    localparam int U_W  = 17;
    localparam int W_W  = 18;
    localparam int G_W  = 49;
    localparam int PH_W = 41;
    localparam int HS_W = 42;
    localparam logic [W_W-1:0] W_BASE = 18'd196608;
    localparam logic [G_W-1:0] G_ONE  = {1'b1, 48'd0};
    localparam logic [HS_W-1:0] H_ROUND = 42'd8388608;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF3  = 3'd5;

    // register reset values
    localparam logic [FIELD_W-1:0] FREQ_RESET = 16'd256;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ADV,
        S_CLK,
        S_SIN,
        S_COS,
        S_G,
        S_GSUM,
        S_HHI,
        S_HLO,
        S_HSUM,
        S_OUT
    } t_state;

    typedef logic [LEG_W-1:0] t_leg;

    // one table entry: sin(pi/2 * i / depth) in Q1.14 from a Taylor series in Q30
    function automatic logic [SINE_MAG_W-1:0] sine_entry(input int unsigned i);
        longint x;
        longint term;
        longint sum;
        longint r;
        x = (HALF_PI_Q30 * longint'(i)) / SINE_DEPTH;
        term = x;
        sum = x;
        for (int k = 1; k <= 8; k++) begin
            term = (term * x) >>> 30;
            term = (term * x) >>> 30;
            case (k)
                1: term = term / 6;
                2: term = term / 20;
                3: term = term / 42;
                4: term = term / 72;
                5: term = term / 110;
                6: term = term / 156;
                7: term = term / 210;
                default: term = term / 272;
            endcase
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (sum + 64'sd32768) >>> 16;
        if (r > 16384) begin
            r = 16384;
        end
        return r[SINE_MAG_W-1:0];
    endfunction

endpackage

### design/lgpg_mul.sv
// ============================================================================
// lgpg_mul
// shared unsigned multiplier with registered product
// ============================================================================
module lgpg_mul (
    input  logic                          i_clk,
    input  logic [lgpg_pkg::MUL_A_W-1:0]  i_a,
    input  logic [lgpg_pkg::MUL_B_W-1:0]  i_b,
    output logic [lgpg_pkg::MUL_P_W-1:0]  o_p
);

    logic [lgpg_pkg::MUL_P_W-1:0] r_p;

    // one product per cycle, available the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_p <= lgpg_pkg::MUL_P_W'(i_a) * lgpg_pkg::MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

### design/lgpg_sine.sv
// ============================================================================
// lgpg_sine
// sine of a phase in turns from a quarter-wave table, signed Q1.14 result
// ============================================================================
module lgpg_sine #(
    parameter int PHASE_BITS = 16
) (
    input  logic [PHASE_BITS-1:0] i_phase,
    output logic [15:0]           o_value
);

    localparam int QB = PHASE_BITS - 2;
    localparam int AW = lgpg_pkg::SINE_ADDR_W;
    localparam int MW = lgpg_pkg::SINE_MAG_W;

    logic [MW-1:0]      w_rom [lgpg_pkg::SINE_DEPTH+1];
    logic [1:0]         w_quad;
    logic [QB+AW-1:0]   w_ix;
    logic [AW-1:0]      w_idx;
    logic [AW:0]        w_addr;
    logic [MW-1:0]      w_mag;
    logic [15:0]        w_mag16;

    // constant table, one entry per step of a quarter turn plus the end point
    for (genvar g = 0; g <= lgpg_pkg::SINE_DEPTH; g++) begin : g_rom
        assign w_rom[g] = lgpg_pkg::sine_entry(g);
    end

    // position within the quarter scaled to table depth
    assign w_quad = i_phase[PHASE_BITS-1 -: 2];
    assign w_ix   = {i_phase[QB-1:0], {AW{1'b0}}};
    assign w_idx  = w_ix[QB+AW-1 -: AW];

    // odd quarters read backwards, the lower half turn negates
    assign w_addr  = w_quad[0] ? ((AW+1)'(lgpg_pkg::SINE_DEPTH) - {1'b0, w_idx})
                               : {1'b0, w_idx};
    assign w_mag   = w_rom[w_addr];
    assign w_mag16 = {1'b0, w_mag};
    assign o_value = w_quad[1] ? (16'd0 - w_mag16) : w_mag16;

endmodule

### design/legged_gait_phase_generator_core.sv
// ============================================================================
// legged_gait_phase_generator_core
// gait clock with per-leg cosine, sine and cubic swing height
// ============================================================================
// an accepted item steps through S_ADV and S_CLK, then S_SIN to S_HSUM for each leg, then S_OUT
// one item at a time: not ready from acceptance until S_OUT loads the output register
// the long leg sequence comes from the single shared multiplier, used four times per leg in sequence
// a finished result waits in the output register while the next item is taken
// reset (synchronous, active low): gait clock zero, frequency 1.0, swing height and offsets zero
`include "legged_gait_phase_generator_core_macros.svh"

module legged_gait_phase_generator_core #(
    parameter int PHASE_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: time_step, extra_offset_leg0, extra_offset_leg1, extra_offset_leg2,
    //        extra_offset_leg3
    input  logic [79:0]  s_axis_tdata,
    // tuser: req_type
    input  logic         s_axis_tuser,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: height_leg0..3, cosine_leg0..3, sine_leg0..3
    output logic [191:0] m_axis_tdata
);

    localparam int PB = PHASE_BITS;
    localparam int QB = PHASE_BITS - 2;
    localparam int FW = lgpg_pkg::FIELD_W;
    localparam logic [PB-1:0] Q_PH    = {2'b01, {QB{1'b0}}};
    localparam logic [PB-1:0] HALF_PH = {2'b10, {QB{1'b0}}};

    // control state
    lgpg_pkg::t_state r_state, n_state;
    lgpg_pkg::t_leg   r_leg, n_leg;
    logic             r_out_valid;
    logic             w_out_load;
    logic             w_in_accept;

    // gait clock and configuration
    logic [31:0]      r_clock;
    logic [FW-1:0]    r_freq;
    logic [FW-1:0]    r_swing;
    logic [FW-1:0]    r_off [lgpg_pkg::SLOTS];

    // captured item
    logic             r_req_reset;
    logic [FW-1:0]    r_ts;
    logic [FW-1:0]    r_extra [lgpg_pkg::SLOTS];

    // per-leg working registers
    logic [PB-1:0]            r_base;
    logic [lgpg_pkg::U_W-1:0] r_u;
    logic                     r_fall;
    logic                     r_none;
    logic                     r_u2_top;
    logic [lgpg_pkg::G_W-1:0] r_g;
    logic [lgpg_pkg::PH_W-1:0] r_phi;

    // results of the item being worked on, and the output register
    logic [FW-1:0]    r_height [lgpg_pkg::SLOTS];
    logic [FW-1:0]    r_cos [lgpg_pkg::SLOTS];
    logic [FW-1:0]    r_sin [lgpg_pkg::SLOTS];
    logic [lgpg_pkg::OUT_W-1:0] r_out_data;

    // combinational datapath
    logic [PB-1:0]            w_clk_ph;
    logic [PB+15:0]           w_off_ext;
    logic [PB+15:0]           w_ext_ext;
    logic [PB-1:0]            w_base;
    logic [PB-1:0]            w_hp;
    logic [PB-1:0]            w_hp_mq;
    logic                     w_rise;
    logic                     w_fall;
    logic [QB:0]              w_hx;
    logic [QB+16:0]           w_ux;
    logic [PB-1:0]            w_sin_ph;
    logic [15:0]              w_sin_val;
    logic [lgpg_pkg::W_W-1:0] w_w;
    logic [lgpg_pkg::G_W-1:0] w_g_raw;
    logic [lgpg_pkg::G_W-1:0] w_g;
    logic [lgpg_pkg::HS_W-1:0] w_hsum;
    logic [FW-1:0]            w_height;
    logic [lgpg_pkg::MUL_A_W-1:0] w_mul_a;
    logic [lgpg_pkg::MUL_B_W-1:0] w_mul_b;
    logic [lgpg_pkg::MUL_P_W-1:0] w_prod;

    assign w_in_accept   = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == lgpg_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // base and height phases of the current leg
    assign w_clk_ph  = r_clock[31 -: PB];
    assign w_off_ext = {r_off[r_leg], {PB{1'b0}}};
    assign w_ext_ext = {r_extra[r_leg], {PB{1'b0}}};
    assign w_base    = w_clk_ph + w_off_ext[PB+15 -: PB];
    assign w_hp      = w_base + w_ext_ext[PB+15 -: PB];
    assign w_hp_mq   = w_hp - Q_PH;
    assign w_rise    = (w_hp <= Q_PH);
    assign w_fall    = !w_rise && (w_hp <= HALF_PH);
    assign w_hx      = w_rise ? w_hp[QB:0] : w_hp_mq[QB:0];
    assign w_ux      = {w_hx, 16'd0};

    // sine lookup, shared by the sine and cosine steps
    assign w_sin_ph = (r_state == lgpg_pkg::S_COS) ? (r_base + Q_PH) : w_base;

    lgpg_sine #(
        .PHASE_BITS (PB)
    ) u_sine (
        .i_phase (w_sin_ph),
        .o_value (w_sin_val)
    );

    // cubic: g = u^2 * (3 * 2^16 - 2u), mirrored for the falling quarter
    assign w_w     = lgpg_pkg::W_BASE - {r_u, 1'b0};
    assign w_g_raw = w_prod[lgpg_pkg::G_W-1:0]
                   + (r_u2_top ? {w_w[16:0], 32'd0} : '0);
    assign w_g     = r_fall ? (lgpg_pkg::G_ONE - w_g_raw) : w_g_raw;

    // height = (swing * g + 2^47) >> 48 from the two partial products
    assign w_hsum   = {1'b0, r_phi} + lgpg_pkg::HS_W'(w_prod[39:24]) + lgpg_pkg::H_ROUND;
    assign w_height = r_none ? '0 : w_hsum[39:24];

    // operand select for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            lgpg_pkg::S_ADV: begin
                w_mul_a = lgpg_pkg::MUL_A_W'(r_ts);
                w_mul_b = lgpg_pkg::MUL_B_W'(r_freq);
            end
            lgpg_pkg::S_COS: begin
                w_mul_a = lgpg_pkg::MUL_A_W'(r_u);
                w_mul_b = lgpg_pkg::MUL_B_W'(r_u);
            end
            lgpg_pkg::S_G: begin
                w_mul_a = w_prod[31:0];
                w_mul_b = lgpg_pkg::MUL_B_W'(w_w);
            end
            lgpg_pkg::S_HHI: begin
                w_mul_a = lgpg_pkg::MUL_A_W'(r_swing);
                w_mul_b = r_g[48:24];
            end
            lgpg_pkg::S_HLO: begin
                w_mul_a = lgpg_pkg::MUL_A_W'(r_swing);
                w_mul_b = lgpg_pkg::MUL_B_W'(r_g[23:0]);
            end
            default: begin
            end
        endcase
    end

    lgpg_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // sequencer: next state and strobes
    always_comb begin
        n_state    = r_state;
        n_leg      = r_leg;
        w_out_load = 1'b0;
        case (r_state)
            lgpg_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = lgpg_pkg::S_ADV;
                end
            end
            lgpg_pkg::S_ADV: begin
                n_state = lgpg_pkg::S_CLK;
            end
            lgpg_pkg::S_CLK: begin
                n_leg   = '0;
                n_state = lgpg_pkg::S_SIN;
            end
            lgpg_pkg::S_SIN: begin
                n_state = lgpg_pkg::S_COS;
            end
            lgpg_pkg::S_COS: begin
                n_state = lgpg_pkg::S_G;
            end
            lgpg_pkg::S_G: begin
                n_state = lgpg_pkg::S_GSUM;
            end
            lgpg_pkg::S_GSUM: begin
                n_state = lgpg_pkg::S_HHI;
            end
            lgpg_pkg::S_HHI: begin
                n_state = lgpg_pkg::S_HLO;
            end
            lgpg_pkg::S_HLO: begin
                n_state = lgpg_pkg::S_HSUM;
            end
            lgpg_pkg::S_HSUM: begin
                if (r_leg == lgpg_pkg::LEG_W'(lgpg_pkg::LEG_COUNT - 1)) begin
                    n_state = lgpg_pkg::S_OUT;
                end else begin
                    n_leg   = r_leg + 1'b1;
                    n_state = lgpg_pkg::S_SIN;
                end
            end
            lgpg_pkg::S_OUT: begin
                w_out_load = !r_out_valid || m_axis_tready;
                if (w_out_load) begin
                    n_state = lgpg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lgpg_pkg::S_IDLE;
            end
        endcase
    end

    // control state, gait clock and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lgpg_pkg::S_IDLE;
            r_leg       <= '0;
            r_out_valid <= 1'b0;
            r_clock     <= '0;
            r_freq      <= lgpg_pkg::FREQ_RESET;
            r_swing     <= '0;
            for (int i = 0; i < lgpg_pkg::SLOTS; i++) begin
                r_off[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_leg   <= n_leg;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            // advance or clear the gait clock
            if (r_state == lgpg_pkg::S_CLK) begin
                r_clock <= r_req_reset ? '0 : (r_clock + {w_prod[23:0], 8'd0});
            end
            // register writes
            if (i_cfg_we) begin
                if (i_cfg_index == lgpg_pkg::REG_FREQ) begin
                    r_freq <= i_cfg_data;
                end else if (i_cfg_index == lgpg_pkg::REG_SWING) begin
                    r_swing <= i_cfg_data;
                end else if (i_cfg_index >= lgpg_pkg::REG_OFF0
                             && i_cfg_index <= lgpg_pkg::REG_OFF3) begin
                    r_off[lgpg_pkg::LEG_W'(i_cfg_index - lgpg_pkg::REG_OFF0)] <= i_cfg_data;
                end
            end
        end
    end

    // item capture and per-leg datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_req_reset <= s_axis_tuser;
            r_ts        <= s_axis_tdata[FW-1:0];
            for (int i = 0; i < lgpg_pkg::SLOTS; i++) begin
                r_extra[i]  <= s_axis_tdata[FW*(i+1) +: FW];
                r_height[i] <= '0;
                r_cos[i]    <= '0;
                r_sin[i]    <= '0;
            end
        end
        case (r_state)
            lgpg_pkg::S_SIN: begin
                r_sin[r_leg] <= w_sin_val;
                r_base       <= w_base;
                r_u          <= w_ux[QB+16 -: lgpg_pkg::U_W];
                r_fall       <= w_fall;
                r_none       <= !w_rise && !w_fall;
            end
            lgpg_pkg::S_COS: begin
                r_cos[r_leg] <= w_sin_val;
            end
            lgpg_pkg::S_G: begin
                r_u2_top <= w_prod[32];
            end
            lgpg_pkg::S_GSUM: begin
                r_g <= w_g;
            end
            lgpg_pkg::S_HLO: begin
                r_phi <= w_prod[lgpg_pkg::PH_W-1:0];
            end
            lgpg_pkg::S_HSUM: begin
                r_height[r_leg] <= w_height;
            end
            default: begin
            end
        endcase
        // pack the finished item into the output register
        if (w_out_load) begin
            for (int i = 0; i < lgpg_pkg::SLOTS; i++) begin
                r_out_data[FW*i +: FW]                      <= r_height[i];
                r_out_data[FW*(lgpg_pkg::SLOTS + i) +: FW]   <= r_cos[i];
                r_out_data[FW*(2*lgpg_pkg::SLOTS + i) +: FW] <= r_sin[i];
            end
        end
    end

    // checks
    `LGPG_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_accept, !s_axis_tready, "input taken while an item is in progress")
    `LGPG_ASSERT_NEXT(a_clock_cleared, i_clk, i_rst_n, (r_state == lgpg_pkg::S_CLK) && r_req_reset, r_clock == '0, "reset item did not clear the gait clock")
    `LGPG_ASSERT_NEXT(a_stance_zero, i_clk, i_rst_n, (r_state == lgpg_pkg::S_HSUM) && r_none, r_height[$past(r_leg)] == '0, "stance leg reported nonzero height")
    `LGPG_ASSERT_NOW(a_load_only_at_end, i_clk, i_rst_n, w_out_load, r_state == lgpg_pkg::S_OUT && n_state == lgpg_pkg::S_IDLE, "output register loaded outside the final step")

endmodule

### verif/tb_top.sv
// ============================================================================
// tb_top
// self-checking bench for the legged gait phase generator: a local predictor
// of the gait clock, table sine and cubic swing height scores every result
// transaction, under random source gaps, sink stalls and one long sink hold
// ============================================================================
module tb_top;

    // request kinds carried on s_axis_tuser
    localparam logic REQ_STEP  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam int     LEGS         = 4;
    localparam int     TABLE_DEPTH  = 256;
    localparam longint HALF_PI_Q30  = 64'sd1686629713;
    localparam longint ONE_Q30      = 64'sd1073741824;
    localparam logic [15:0] QUARTER_TURN = 16'h4000;
    localparam logic [15:0] HALF_TURN    = 16'h8000;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     CYCLE_LIMIT  = 1000000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_index;
    logic [15:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // tdata: time_step, extra_offset_leg0, extra_offset_leg1, extra_offset_leg2,
    //        extra_offset_leg3
    logic [79:0]  s_axis_tdata;
    // tuser: req_type
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // tdata: height_leg0..3, cosine_leg0..3, sine_leg0..3
    logic [191:0] m_axis_tdata;

    // predictor state and register copies
    logic [31:0]  gait_clock;
    logic [15:0]  cfg_freq;
    logic [15:0]  cfg_swing;
    logic [15:0]  cfg_leg_offset [LEGS];
    logic [15:0]  sine_quarter [0:TABLE_DEPTH];

    logic [191:0] leg_report_q [$];
    int           mismatch_count;
    int           cycle_count;
    bit           idle_enable;
    int           sink_hold;

    legged_gait_phase_generator_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // one quarter-wave entry, taylor series in q30 rounded to q1.14
    function automatic logic [15:0] taylor_sine(input int i);
        longint x;
        longint term;
        longint sum;
        longint r;
        x = (HALF_PI_Q30 * longint'(i)) / TABLE_DEPTH;
        term = x;
        sum = x;
        for (int k = 1; k <= 8; k++) begin
            term = (term * x) / ONE_Q30;
            term = (term * x) / ONE_Q30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (sum + 32768) / 65536;
        if (r > 16384) begin
            r = 16384;
        end
        return r[15:0];
    endfunction

    // sine of a q0.16 phase by quarter symmetry
    function automatic logic [15:0] table_sine(input logic [15:0] p);
        logic [7:0]  idx;
        logic [15:0] mag;
        idx = p[13:6];
        mag = p[14] ? sine_quarter[TABLE_DEPTH - int'(idx)] : sine_quarter[idx];
        if (p[15]) begin
            return 16'h0000 - mag;
        end
        return mag;
    endfunction

    // 3u^2 - 2u^3 in q0.48 for a phase within one quarter
    function automatic logic [63:0] swing_cubic(input logic [15:0] x);
        logic [63:0] u;
        u = 64'(x) << 2;
        return 64'd3 * u * u * 64'd65536 - 64'd2 * u * u * u;
    endfunction

    // rising quarter, falling quarter, then flat on the ground
    function automatic logic [15:0] foot_height(input logic [15:0] hp);
        logic [63:0] g;
        logic [63:0] prod;
        if (hp <= QUARTER_TURN) begin
            g = swing_cubic(hp);
        end else if (hp <= HALF_TURN) begin
            g = (64'd1 << 48) - swing_cubic(hp - QUARTER_TURN);
        end else begin
            return 16'd0;
        end
        prod = 64'(cfg_swing) * g + (64'd1 << 47);
        return prod[63:48];
    endfunction

    // update the gait clock and work out the four-leg report
    function automatic logic [191:0] gait_predict(input logic req,
                                                  input logic [79:0] data);
        logic [191:0] rep;
        logic [31:0]  prod;
        logic [15:0]  clk16;
        logic [15:0]  base;
        logic [15:0]  hp;
        rep = '0;
        if (req == REQ_CLEAR) begin
            gait_clock = 32'd0;
        end else begin
            prod = 32'(data[15:0]) * 32'(cfg_freq);
            gait_clock = gait_clock + (prod << 8);
        end
        clk16 = gait_clock[31:16];
        for (int leg = 0; leg < LEGS; leg++) begin
            base = clk16 + cfg_leg_offset[leg];
            hp   = base + data[16 + 16 * leg +: 16];
            rep[16 * leg +: 16]       = foot_height(hp);
            rep[64 + 16 * leg +: 16]  = table_sine(base + QUARTER_TURN);
            rep[128 + 16 * leg +: 16] = table_sine(base);
        end
        return rep;
    endfunction

    function automatic string field_name(input int f);
        case (f / LEGS)
            0:       return $sformatf("height_leg%0d", f % LEGS);
            1:       return $sformatf("cosine_leg%0d", f % LEGS);
            default: return $sformatf("sine_leg%0d", f % LEGS);
        endcase
    endfunction

    // register write, only while the block is idle
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_index = 3'($urandom_range(0, 7));
        i_cfg_data  = 16'($urandom_range(0, 65535));
        if (idx == lgpg_pkg::REG_FREQ) begin
            cfg_freq = val;
        end else if (idx == lgpg_pkg::REG_SWING) begin
            cfg_swing = val;
        end else if (idx >= lgpg_pkg::REG_OFF0 && idx <= lgpg_pkg::REG_OFF3) begin
            cfg_leg_offset[idx - lgpg_pkg::REG_OFF0] = val;
        end
    endtask

    task automatic write_all(input logic [15:0] freq, input logic [15:0] swing,
                             input logic [15:0] o0, input logic [15:0] o1,
                             input logic [15:0] o2, input logic [15:0] o3);
        write_reg(lgpg_pkg::REG_FREQ, freq);
        write_reg(lgpg_pkg::REG_SWING, swing);
        write_reg(lgpg_pkg::REG_OFF0, o0);
        write_reg(lgpg_pkg::REG_OFF0 + 3'd1, o1);
        write_reg(lgpg_pkg::REG_OFF0 + 3'd2, o2);
        write_reg(lgpg_pkg::REG_OFF3, o3);
    endtask

    // offer one transaction, hold it until accepted, then record its report
    task automatic send_item(input logic req, input logic [15:0] ts,
                             input logic [15:0] e0, input logic [15:0] e1,
                             input logic [15:0] e2, input logic [15:0] e3);
        int gap;
        @(negedge i_clk);
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = 80'({$urandom, $urandom, $urandom});
            s_axis_tuser  = 1'($urandom_range(0, 1));
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req;
        s_axis_tdata  = {e3, e2, e1, e0, ts};
        do @(posedge i_clk); while (!s_axis_tready);
        leg_report_q.push_back(gait_predict(req, {e3, e2, e1, e0, ts}));
    endtask

    // wait until every report is back and the block has settled
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (leg_report_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // extra offsets biased toward the swing window edges
    function automatic logic [15:0] pick_extra();
        case ($urandom_range(0, 9))
            0:       return QUARTER_TURN + 16'($urandom_range(0, 2)) - 16'd1;
            1:       return HALF_TURN + 16'($urandom_range(0, 2)) - 16'd1;
            2:       return pick_word();
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // defaults after reset: frequency 1.0, no swing, no offsets
    task automatic test_reset_defaults();
        send_item(REQ_STEP, 16'h0000, 16'h0000, 16'h4000, 16'h8000, 16'hFFFF);
        send_item(REQ_STEP, 16'hFFFF, 16'h1234, 16'h0000, 16'hFFFF, 16'h4000);
        send_item(REQ_CLEAR, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drain_results();
    endtask

    // swing window bounds with a frozen clock (zero frequency)
    task automatic test_swing_edges();
        write_all(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(REQ_CLEAR, 16'h0000, 16'h0000, 16'h4000, 16'h8000, 16'hFFFF);
        send_item(REQ_STEP, 16'hFFFF, 16'h3FFF, 16'h4001, 16'h7FFF, 16'h8001);
        send_item(REQ_STEP, 16'h8000, 16'h2000, 16'h6000, 16'h0001, 16'hC000);
        send_item(REQ_STEP, 16'h0001, 16'h1000, 16'h7000, 16'hA000, 16'h5555);
        drain_results();
    endtask

    // largest step times largest frequency wraps the clock
    task automatic test_clock_wrap();
        write_all(16'hFFFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(REQ_STEP, 16'hFFFF, 16'h0000, 16'h1111, 16'h2222, 16'h3333);
        send_item(REQ_STEP, 16'hFFFF, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h0000);
        send_item(REQ_STEP, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'hE000);
        send_item(REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(REQ_STEP, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drain_results();
    endtask

    // leg offsets at the quarter points and at the top of the range
    task automatic test_leg_offsets();
        write_all(16'h0100, 16'h0001, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000);
        send_item(REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(REQ_STEP, 16'h4000, 16'h0001, 16'hFFFF, 16'h8000, 16'h4000);
        drain_results();
        write_reg(lgpg_pkg::REG_SWING, 16'h7FFF);
        send_item(REQ_STEP, 16'h2000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(REQ_STEP, 16'hC000, 16'h3000, 16'h3000, 16'h3000, 16'h3000);
        send_item(REQ_STEP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain_results();
    endtask

    // sink holds off for a long stretch while the source keeps offering
    task automatic test_output_backpressure();
        sink_hold = 400;
        repeat (6) begin
            send_item($urandom_range(0, 7) == 0, 16'($urandom_range(0, 65535)),
                      pick_extra(), pick_extra(), pick_extra(), pick_extra());
        end
        drain_results();
    endtask

    // one random register setting followed by random transactions
    task automatic test_random_traffic(input int count);
        logic [15:0] swing;
        swing = ($urandom_range(0, 5) == 0) ? pick_word() : 16'($urandom_range(1, 65535));
        write_all(pick_word(), swing, pick_word(), pick_word(), pick_word(), pick_word());
        repeat (count) begin
            send_item(($urandom_range(0, 15) == 0) ? REQ_CLEAR : REQ_STEP, pick_word(),
                      pick_extra(), pick_extra(), pick_extra(), pick_extra());
        end
        drain_results();
    endtask

    // sink side: long hold on request, random stall bursts otherwise
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                m_axis_tready = 1'b0;
                sink_hold--;
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if (idle_enable && $urandom_range(0, 7) == 0) begin
                m_axis_tready = 1'b0;
                stall_left = $urandom_range(1, 11) - 1;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // score each result transaction against the oldest pending report
    always @(posedge i_clk) begin : score_results
        logic [191:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (leg_report_q.size() == 0) begin
                $error("result transaction with no pending report: 0x%048h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = leg_report_q.pop_front();
                for (int f = 0; f < 3 * LEGS; f++) begin
                    if (m_axis_tdata[16 * f +: 16] !== want[16 * f +: 16]) begin
                        $error("%s expected 0x%04h actual 0x%04h", field_name(f),
                               want[16 * f +: 16], m_axis_tdata[16 * f +: 16]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // test sequence
    initial begin
        mismatch_count = 0;
        cycle_count    = 0;
        sink_hold      = 0;
        idle_enable    = 1'b1;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = REQ_STEP;
        for (int i = 0; i <= TABLE_DEPTH; i++) begin
            sine_quarter[i] = taylor_sine(i);
        end
        gait_clock = 32'd0;
        cfg_freq   = 16'd256;
        cfg_swing  = 16'd0;
        for (int leg = 0; leg < LEGS; leg++) begin
            cfg_leg_offset[leg] = 16'd0;
        end

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_swing_edges();
        test_clock_wrap();
        test_leg_offsets();
        test_output_backpressure();
        repeat (4) test_random_traffic(330);
        idle_enable = 1'b0;
        test_random_traffic(150);

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/lgpg_pkg.sv
design/lgpg_mul.sv
design/lgpg_sine.sv
design/legged_gait_phase_generator_core.sv
verif/tb_top.sv
